// ----- src/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants of the keyframe track sampler
// Holds the stored key layout, the operation codes, the Q1.16 unit weight and
// the control word that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned WgtW   = 17;
  localparam int unsigned CountW = 9;
  localparam int unsigned ProdW  = 50;

  // Operation codes of a request.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Unit weight in Q1.16.
  localparam logic [WgtW-1:0] WEIGHT_ONE = 17'd65536;

  // One stored key: time and the three value components.
  typedef struct packed {
    logic        [ValW-1:0] time_v;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
    logic signed [ValW-1:0] z;
  } key_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;  // register the product of the current operands
    logic acc_en;  // let the accumulator take the registered product on the first term
    logic first;   // first term of a pair: accumulator takes the product
  } mac_ctl_t;

endpackage

// ----- src/kts_req_if.sv -----
// ----------------------------------------------------------------------------
// kts_req_if: request channel of the keyframe track sampler
// Carries valid, ready and the fields of one load or sample request.
// ----------------------------------------------------------------------------
interface kts_req_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        key_index;
  logic [31:0]       key_time;
  logic signed [31:0] key_x;
  logic signed [31:0] key_y;
  logic signed [31:0] key_z;
  logic [31:0]       sample_time;
  logic [16:0]       blend;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] prev_z;

  modport source (
    output valid, operation, key_index, key_time, key_x, key_y, key_z,
           sample_time, blend, prev_x, prev_y, prev_z,
    input  ready
  );

  modport sink (
    input  valid, operation, key_index, key_time, key_x, key_y, key_z,
           sample_time, blend, prev_x, prev_y, prev_z,
    output ready
  );
endinterface

// ----- src/kts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// kts_rsp_if: result channel of the keyframe track sampler
// Carries valid, ready and the three components of one sampled pose.
// ----------------------------------------------------------------------------
interface kts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );
endinterface

// ----- src/kts_mac.sv -----
// ----------------------------------------------------------------------------
// kts_mac: shared multiply-accumulate unit
// Forms a*w into a product register, sums two such products and divides the
// sum by 65536 with truncation toward zero.
// ----------------------------------------------------------------------------
module kts_mac
  import kts_pkg::*;
(
  input  logic                   clk_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [WgtW:0]   w_i,
  input  mac_ctl_t               ctl_i,
  output logic signed [ValW-1:0] res_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] acc_q;
  logic signed [ProdW:0]   sum;
  logic                    round_up;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= a_i * w_i;
    end
    if (ctl_i.acc_en && ctl_i.first) begin
      acc_q <= prod_q;
    end
  end

  // A negative sum with a nonzero fraction moves one step toward zero.
  assign sum      = {acc_q[ProdW-1], acc_q} + {prod_q[ProdW-1], prod_q};
  assign round_up = sum[ProdW] & (|sum[15:0]);
  assign res_o    = sum[ValW+15:16] + {{(ValW-1){1'b0}}, round_up};

endmodule

// ----- src/keyframe_track_sampler_core.sv -----
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core: fixed-point keyframe track sampler
// Sequence: a load request is written to the key memory when accepted. A
//   sample request scans the keys, runs a division when it lands between
//   two keys, then runs the multiply-accumulate sequence and hands over
//   the result.
// Throughput: one request at a time, set by the key scan through the single
//   memory read port and by the one shared multiplier.
// Reset: control state and the key count (reset value 1) clear asynchronously;
//   the key memory is not cleared and holds nothing valid until written.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_core
  import kts_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  kts_req_if.sink           req_i,
  kts_rsp_if.source         rsp_o
);

  // Index width of the key memory and width of a counter that can hold
  // the key count itself.
  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_ACC,
    S_PUT
  } state_e;

  state_e state_q;

  // Configuration register.
  logic [CountW-1:0] key_count_q;

  // Key memory: one entry per key, one write port and one registered read.
  key_t             key_mem [MAX_KEYS];
  key_t             rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  logic             mem_re;

  // Request context latched when a sample request is accepted.
  logic [ValW-1:0]        st_q;
  logic [WgtW-1:0]        blend_q;
  logic signed [ValW-1:0] prev_q [3];

  // Scan state.
  logic [CntW-1:0]  n_q;
  logic [CntW-1:0]  iss_q;
  logic [CntW-1:0]  rd_idx_q;
  logic             rd_vld_q;
  logic             scan_end;
  logic [ValW-1:0]  t0_q;
  logic signed [ValW-1:0] v0_q [3];
  logic signed [ValW-1:0] v1_q [3];

  // Division state: the remainder always stays below the span.
  logic [ValW-1:0]  span_q;
  logic [ValW-1:0]  rem_q;
  logic [3:0]       div_cnt_q;
  logic [WgtW-1:0]  rate_q;
  logic [ValW:0]    rem_sh;
  logic             rem_ge;

  // Multiply-accumulate sequencing.
  logic [3:0]             step_q;
  logic signed [ValW-1:0] cur_q [3];
  logic signed [ValW-1:0] res_q [3];
  logic signed [ValW-1:0] mac_a;
  logic signed [WgtW:0]   mac_w;
  logic signed [ValW-1:0] mac_res;
  mac_ctl_t               mac_ctl;

  logic             req_fire;
  logic             rsp_fire;
  logic [CntW-1:0]  n_sat;
  logic [WgtW-1:0]  blend_sat;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  assign rsp_fire    = rsp_o.valid & rsp_o.ready;

  // A key count of zero scans one key; a count above the memory depth scans
  // the whole memory.
  always_comb begin
    if (key_count_q == '0) begin
      n_sat = CntW'(1);
    end else if (32'(key_count_q) > MAX_KEYS) begin
      n_sat = CntW'(MAX_KEYS);
    end else begin
      n_sat = CntW'(key_count_q);
    end
  end

  assign blend_sat = (req_i.blend > WEIGHT_ONE) ? WEIGHT_ONE : req_i.blend;

  // Loads write in the cycle they are accepted; slots beyond the memory are
  // dropped.
  assign mem_we = req_fire && (req_i.operation == OP_LOAD) &&
                  (32'(req_i.key_index) < MAX_KEYS);
  assign mem_wa = IdxW'(req_i.key_index);
  assign mem_re = (state_q == S_SCAN) && (iss_q != n_q);

  // The key under compare ends the scan when it is later than the sample
  // time or when it is the last key of the track.
  assign scan_end = rd_vld_q &&
                    ((st_q < rd_q.time_v) || (rd_idx_q + CntW'(1) == n_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= '{time_v: req_i.key_time, x: req_i.key_x,
                           y: req_i.key_y, z: req_i.key_z};
    end
    if (mem_re) begin
      rd_q <= key_mem[iss_q[IdxW-1:0]];
    end
  end

  // One restoring division step per cycle gives one bit of the Q0.16 rate.
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, span_q});

  // Operand selection for the shared unit. Each component runs four terms:
  // the two interpolation terms, then the two cross-fade terms.
  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        mac_a = v0_q[step_q[3:2]];
        mac_w = {1'b0, WEIGHT_ONE - rate_q};
      end
      2'd1: begin
        mac_a = v1_q[step_q[3:2]];
        mac_w = {1'b0, rate_q};
      end
      2'd2: begin
        mac_a = prev_q[step_q[3:2]];
        mac_w = {1'b0, WEIGHT_ONE - blend_q};
      end
      default: begin
        mac_a = cur_q[step_q[3:2]];
        mac_w = {1'b0, blend_q};
      end
    endcase
  end

  assign mac_ctl = '{mul_en: (state_q == S_MUL), acc_en: (state_q == S_ACC),
                     first: ~step_q[0]};

  kts_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .w_i   (mac_w),
    .ctl_i (mac_ctl),
    .res_o (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      rsp_o.valid <= 1'b0;
    end else begin
      // In the hand-over state the result register is refilled instead.
      if (rsp_fire && (state_q != S_PUT)) begin
        rsp_o.valid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire && (req_i.operation == OP_SAMPLE)) begin
            st_q      <= req_i.sample_time;
            blend_q   <= blend_sat;
            prev_q[0] <= req_i.prev_x;
            prev_q[1] <= req_i.prev_y;
            prev_q[2] <= req_i.prev_z;
            n_q       <= n_sat;
            iss_q     <= '0;
            rd_vld_q  <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued one key per cycle; the compare works on the registered read data.
          rd_vld_q <= mem_re && !scan_end;
          if (mem_re) begin
            iss_q    <= iss_q + CntW'(1);
            rd_idx_q <= iss_q;
          end
          if (rd_vld_q) begin
            if (st_q < rd_q.time_v) begin
              // First key later than the sample time ends the scan.
              v1_q[0] <= rd_q.x;
              v1_q[1] <= rd_q.y;
              v1_q[2] <= rd_q.z;
              if (rd_idx_q == '0) begin
                v0_q[0] <= rd_q.x;
                v0_q[1] <= rd_q.y;
                v0_q[2] <= rd_q.z;
                rate_q  <= '0;
                step_q  <= '0;
                state_q <= S_MUL;
              end else begin
                span_q    <= rd_q.time_v - t0_q;
                rem_q     <= st_q - t0_q;
                rate_q    <= '0;
                div_cnt_q <= '0;
                state_q   <= S_DIV;
              end
            end else begin
              v0_q[0] <= rd_q.x;
              v0_q[1] <= rd_q.y;
              v0_q[2] <= rd_q.z;
              t0_q    <= rd_q.time_v;
              if (rd_idx_q + CntW'(1) == n_q) begin
                // No later key: hold the last key that is not later.
                v1_q[0]  <= rd_q.x;
                v1_q[1]  <= rd_q.y;
                v1_q[2]  <= rd_q.z;
                rate_q   <= '0;
                step_q   <= '0;
                state_q  <= S_MUL;
              end
            end
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem_q <= ValW'(rem_sh - {1'b0, span_q});
          end else begin
            rem_q <= rem_sh[ValW-1:0];
          end
          rate_q    <= {rate_q[WgtW-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + 4'd1;
          if (div_cnt_q == 4'd15) begin
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (step_q[0]) begin
            if (!step_q[1]) begin
              cur_q[step_q[3:2]] <= mac_res;
            end else begin
              res_q[step_q[3:2]] <= mac_res;
            end
          end
          if (step_q == 4'd11) begin
            state_q <= S_PUT;
          end else begin
            step_q  <= step_q + 4'd1;
            state_q <= S_MUL;
          end
        end
        S_PUT: begin
          // The result register takes the pose once the last one has left.
          if (!rsp_o.valid || rsp_o.ready) begin
            rsp_o.out_x <= res_q[0];
            rsp_o.out_y <= res_q[1];
            rsp_o.out_z <= res_q[2];
            rsp_o.valid <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The division only runs between two keys, so the span is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (span_q != '0) && (rem_q < span_q))
    else $error("division entered with an empty span");

  // The interpolation rate stays below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> !rate_q[WgtW-1])
    else $error("interpolation rate reached one");

  // A new result appears only out of the hand-over state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == S_PUT))
    else $error("result raised outside hand-over");

endmodule
